### rtl/aor_pkg.sv
// ----------------------------------------------------------------------------
// aor_pkg
// Shared types and constants for the box overlap resolver.
// ----------------------------------------------------------------------------
package aor_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int SIZE_BITS      = 24;
    localparam int CFG_BITS       = 16;
    localparam int APB_DATA_BITS  = 32;
    localparam int APB_ADDR_BITS  = 3;

    localparam int STAIR_HEIGHT_INT = 20;
    localparam int STAIR_SHIFT_INT  = 5;

    localparam logic REG_STAIR_HEIGHT = 1'b0;
    localparam logic REG_STAIR_SHIFT  = 1'b1;

    typedef enum logic [1:0] {
        PUSH_NONE  = 2'd0,
        PUSH_VERT  = 2'd1,
        PUSH_HORIZ = 2'd2,
        PUSH_STAIR = 2'd3
    } push_kind_t;

    typedef struct packed {
        logic [CFG_BITS-1:0] stair_height;
        logic [CFG_BITS-1:0] stair_shift;
    } cfg_t;

    typedef struct packed {
        logic enable;
        logic hit;
    } pair_flags_t;

endpackage

### rtl/aor_cfg.sv
// ----------------------------------------------------------------------------
// aor_cfg
// APB register file holding the stair step height and shift.
// ----------------------------------------------------------------------------
module aor_cfg #(
    parameter int FRAC_BITS = aor_pkg::FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [aor_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [aor_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [aor_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                               pready,
    output aor_pkg::cfg_t                      cfg
);
    import aor_pkg::*;

    localparam logic [31:0] HEIGHT_RST_W = 32'(STAIR_HEIGHT_INT) << FRAC_BITS;
    localparam logic [31:0] SHIFT_RST_W  = 32'(STAIR_SHIFT_INT) << FRAC_BITS;

    logic [CFG_BITS-1:0] height_reg;
    logic [CFG_BITS-1:0] shift_reg;
    logic                wr_en;
    logic                reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            height_reg <= HEIGHT_RST_W[CFG_BITS-1:0];
            shift_reg  <= SHIFT_RST_W[CFG_BITS-1:0];
        end else if (wr_en) begin
            case (reg_sel)
                REG_STAIR_HEIGHT: height_reg <= pwdata[CFG_BITS-1:0];
                REG_STAIR_SHIFT:  shift_reg  <= pwdata[CFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_STAIR_HEIGHT: prdata = {{(APB_DATA_BITS-CFG_BITS){1'b0}}, height_reg};
            REG_STAIR_SHIFT:  prdata = {{(APB_DATA_BITS-CFG_BITS){1'b0}}, shift_reg};
            default:          prdata = '0;
        endcase
    end

    assign cfg.stair_height = height_reg;
    assign cfg.stair_shift  = shift_reg;

endmodule

### rtl/aor_measure.sv
// ----------------------------------------------------------------------------
// aor_measure
// Two pipeline stages: side overlaps of the pair, then their magnitudes
// and the strict overlap test.
// ----------------------------------------------------------------------------
module aor_measure #(
    parameter int COORD_BITS = aor_pkg::COORD_BITS_DEF,
    parameter int WIDE_BITS  = 27
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [COORD_BITS-1:0]       mover_x,
    input  logic signed [COORD_BITS-1:0]       mover_y,
    input  logic [aor_pkg::SIZE_BITS-1:0]      mover_w,
    input  logic [aor_pkg::SIZE_BITS-1:0]      mover_h,
    input  logic signed [COORD_BITS-1:0]       mover_vx,
    input  logic signed [COORD_BITS-1:0]       mover_vy,
    input  logic signed [COORD_BITS-1:0]       obstacle_x,
    input  logic signed [COORD_BITS-1:0]       obstacle_y,
    input  logic [aor_pkg::SIZE_BITS-1:0]      obstacle_w,
    input  logic [aor_pkg::SIZE_BITS-1:0]      obstacle_h,
    input  logic                               enable,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [COORD_BITS-1:0]       ax,
    output logic signed [COORD_BITS-1:0]       ay,
    output logic signed [COORD_BITS-1:0]       vx,
    output logic signed [COORD_BITS-1:0]       vy,
    output logic signed [WIDE_BITS-1:0]        ol,
    output logic signed [WIDE_BITS-1:0]        orr,
    output logic signed [WIDE_BITS-1:0]        ot,
    output logic signed [WIDE_BITS-1:0]        obt,
    output logic [WIDE_BITS-1:0]               abs_ol,
    output logic [WIDE_BITS-1:0]               abs_orr,
    output logic [WIDE_BITS-1:0]               abs_ot,
    output logic [WIDE_BITS-1:0]               abs_obt,
    output aor_pkg::pair_flags_t               flags
);
    import aor_pkg::*;

    localparam int CX = WIDE_BITS - COORD_BITS;
    localparam int SX = WIDE_BITS - SIZE_BITS;

    // stage 1
    logic                        v1_reg;
    logic                        rdy1;
    logic signed [WIDE_BITS-1:0] ax_w, ay_w, bx_w, by_w;
    logic signed [WIDE_BITS-1:0] aw_w, ah_w, bw_w, bh_w;
    logic signed [COORD_BITS-1:0] ax1_reg, ay1_reg, vx1_reg, vy1_reg;
    logic signed [WIDE_BITS-1:0] ol1_reg, orr1_reg, ot1_reg, obt1_reg;
    logic                        en1_reg, size1_reg;

    // stage 2
    logic                        v2_reg;
    logic                        rdy2;
    logic signed [COORD_BITS-1:0] ax2_reg, ay2_reg, vx2_reg, vy2_reg;
    logic signed [WIDE_BITS-1:0] ol2_reg, orr2_reg, ot2_reg, obt2_reg;
    logic [WIDE_BITS-1:0]        aol2_reg, aorr2_reg, aot2_reg, aobt2_reg;
    pair_flags_t                 flags2_reg;
    logic                        hit_next;

    function automatic logic [WIDE_BITS-1:0] mag_w(input logic signed [WIDE_BITS-1:0] v);
        logic [WIDE_BITS-1:0] r;
        r = v[WIDE_BITS-1] ? WIDE_BITS'(-v) : WIDE_BITS'(v);
        return r;
    endfunction

    function automatic logic pos_w(input logic signed [WIDE_BITS-1:0] v);
        logic r;
        r = !v[WIDE_BITS-1] && (|v);
        return r;
    endfunction

    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    assign ax_w = {{CX{mover_x[COORD_BITS-1]}}, mover_x};
    assign ay_w = {{CX{mover_y[COORD_BITS-1]}}, mover_y};
    assign bx_w = {{CX{obstacle_x[COORD_BITS-1]}}, obstacle_x};
    assign by_w = {{CX{obstacle_y[COORD_BITS-1]}}, obstacle_y};
    assign aw_w = {{SX{1'b0}}, mover_w};
    assign ah_w = {{SX{1'b0}}, mover_h};
    assign bw_w = {{SX{1'b0}}, obstacle_w};
    assign bh_w = {{SX{1'b0}}, obstacle_h};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            ax1_reg   <= mover_x;
            ay1_reg   <= mover_y;
            vx1_reg   <= mover_vx;
            vy1_reg   <= mover_vy;
            ol1_reg   <= ax_w + aw_w - bx_w;
            orr1_reg  <= bx_w + bw_w - ax_w;
            ot1_reg   <= ay_w + ah_w - by_w;
            obt1_reg  <= by_w + bh_w - ay_w;
            en1_reg   <= enable;
            size1_reg <= (|mover_w) && (|mover_h) && (|obstacle_w) && (|obstacle_h);
        end
    end

    assign hit_next = size1_reg && pos_w(ol1_reg) && pos_w(orr1_reg)
                      && pos_w(ot1_reg) && pos_w(obt1_reg);

    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) begin
            ax2_reg           <= ax1_reg;
            ay2_reg           <= ay1_reg;
            vx2_reg           <= vx1_reg;
            vy2_reg           <= vy1_reg;
            ol2_reg           <= ol1_reg;
            orr2_reg          <= orr1_reg;
            ot2_reg           <= ot1_reg;
            obt2_reg          <= obt1_reg;
            aol2_reg          <= mag_w(ol1_reg);
            aorr2_reg         <= mag_w(orr1_reg);
            aot2_reg          <= mag_w(ot1_reg);
            aobt2_reg         <= mag_w(obt1_reg);
            flags2_reg.enable <= en1_reg;
            flags2_reg.hit    <= hit_next;
        end
    end

    assign out_valid = v2_reg;
    assign ax        = ax2_reg;
    assign ay        = ay2_reg;
    assign vx        = vx2_reg;
    assign vy        = vy2_reg;
    assign ol        = ol2_reg;
    assign orr       = orr2_reg;
    assign ot        = ot2_reg;
    assign obt       = obt2_reg;
    assign abs_ol    = aol2_reg;
    assign abs_orr   = aorr2_reg;
    assign abs_ot    = aot2_reg;
    assign abs_obt   = aobt2_reg;
    assign flags     = flags2_reg;

endmodule

### rtl/aor_resolve.sv
// ----------------------------------------------------------------------------
// aor_resolve
// Two pipeline stages: side choice per axis, then the push, the stair
// step and saturation into the output register.
// ----------------------------------------------------------------------------
module aor_resolve #(
    parameter int COORD_BITS = aor_pkg::COORD_BITS_DEF,
    parameter int WIDE_BITS  = 27
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  aor_pkg::cfg_t                      cfg,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [COORD_BITS-1:0]       ax,
    input  logic signed [COORD_BITS-1:0]       ay,
    input  logic signed [COORD_BITS-1:0]       vx,
    input  logic signed [COORD_BITS-1:0]       vy,
    input  logic signed [WIDE_BITS-1:0]        ol,
    input  logic signed [WIDE_BITS-1:0]        orr,
    input  logic signed [WIDE_BITS-1:0]        ot,
    input  logic signed [WIDE_BITS-1:0]        obt,
    input  logic [WIDE_BITS-1:0]               abs_ol,
    input  logic [WIDE_BITS-1:0]               abs_orr,
    input  logic [WIDE_BITS-1:0]               abs_ot,
    input  logic [WIDE_BITS-1:0]               abs_obt,
    input  aor_pkg::pair_flags_t               flags,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               hit,
    output logic                               moved,
    output logic signed [COORD_BITS-1:0]       new_x,
    output logic signed [COORD_BITS-1:0]       new_y,
    output logic signed [COORD_BITS-1:0]       new_vx,
    output logic signed [COORD_BITS-1:0]       new_vy,
    output logic                               from_left,
    output logic                               from_top,
    output aor_pkg::push_kind_t                push_kind
);
    import aor_pkg::*;

    localparam int CX = WIDE_BITS - COORD_BITS;
    localparam int HX = WIDE_BITS - CFG_BITS;
    localparam int TX = WIDE_BITS - COORD_BITS + 1;

    // stage 3
    logic                         v3_reg;
    logic                         rdy3;
    logic signed [COORD_BITS-1:0] ax3_reg, ay3_reg, vx3_reg, vy3_reg;
    logic signed [WIDE_BITS-1:0]  mx3_reg, my3_reg;
    logic [WIDE_BITS-1:0]         amx3_reg, amy3_reg;
    logic                         left3_reg, top3_reg;
    pair_flags_t                  flags3_reg;
    logic                         left_next, top_next;

    // stage 4
    logic                         v4_reg;
    logic                         rdy4;
    logic                         hit_reg, moved_reg, left_reg, top_reg;
    logic signed [COORD_BITS-1:0] x_reg, y_reg, vx_reg, vy_reg;
    push_kind_t                   kind_reg;

    logic signed [WIDE_BITS-1:0]  ax_w, ay_w, nx_w, ny_w, sh_w, sf_w;
    logic signed [COORD_BITS-1:0] nvx, nvy;
    push_kind_t                   kind;

    function automatic logic [COORD_BITS-1:0] sat_c(input logic signed [WIDE_BITS-1:0] v);
        logic [TX-1:0]         top_bits;
        logic [COORD_BITS-1:0] r;
        top_bits = v[WIDE_BITS-1:COORD_BITS-1];
        if ((&top_bits) || !(|top_bits)) begin
            r = v[COORD_BITS-1:0];
        end else if (v[WIDE_BITS-1]) begin
            r = {1'b1, {(COORD_BITS-1){1'b0}}};
        end else begin
            r = {1'b0, {(COORD_BITS-1){1'b1}}};
        end
        return r;
    endfunction

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign in_ready = rdy3;

    assign left_next = abs_ol < abs_orr;
    assign top_next  = abs_ot < abs_obt;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy3) begin
                v3_reg <= in_valid;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy3 && in_valid) begin
            ax3_reg    <= ax;
            ay3_reg    <= ay;
            vx3_reg    <= vx;
            vy3_reg    <= vy;
            mx3_reg    <= left_next ? ol : orr;
            my3_reg    <= top_next ? ot : obt;
            amx3_reg   <= left_next ? abs_ol : abs_orr;
            amy3_reg   <= top_next ? abs_ot : abs_obt;
            left3_reg  <= left_next;
            top3_reg   <= top_next;
            flags3_reg <= flags;
        end
    end

    assign ax_w = {{CX{ax3_reg[COORD_BITS-1]}}, ax3_reg};
    assign ay_w = {{CX{ay3_reg[COORD_BITS-1]}}, ay3_reg};
    assign sh_w = {{HX{1'b0}}, cfg.stair_height};
    assign sf_w = {{HX{1'b0}}, cfg.stair_shift};

    always_comb begin
        nx_w = ax_w;
        ny_w = ay_w;
        nvx  = vx3_reg;
        nvy  = vy3_reg;
        kind = PUSH_NONE;
        if (flags3_reg.hit && flags3_reg.enable) begin
            if (amx3_reg > amy3_reg) begin
                nvy  = '0;
                ny_w = top3_reg ? ay_w - my3_reg : ay_w + my3_reg;
                kind = PUSH_VERT;
            end else if (amx3_reg < amy3_reg) begin
                if (top3_reg && (my3_reg < sh_w)) begin
                    nvy  = '0;
                    nx_w = ax_w - sf_w;
                    ny_w = ay_w - my3_reg;
                    kind = PUSH_STAIR;
                end else begin
                    nvx  = '0;
                    nx_w = left3_reg ? ax_w - mx3_reg : ax_w + mx3_reg;
                    kind = PUSH_HORIZ;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy4 && v3_reg) begin
            hit_reg   <= flags3_reg.hit;
            moved_reg <= (kind != PUSH_NONE);
            x_reg     <= sat_c(nx_w);
            y_reg     <= sat_c(ny_w);
            vx_reg    <= nvx;
            vy_reg    <= nvy;
            left_reg  <= left3_reg;
            top_reg   <= top3_reg;
            kind_reg  <= kind;
        end
    end

    assign out_valid = v4_reg;
    assign hit       = hit_reg;
    assign moved     = moved_reg;
    assign new_x     = x_reg;
    assign new_y     = y_reg;
    assign new_vx    = vx_reg;
    assign new_vy    = vy_reg;
    assign from_left = left_reg;
    assign from_top  = top_reg;
    assign push_kind = kind_reg;

endmodule

### rtl/aabb_overlap_resolve.sv
// ----------------------------------------------------------------------------
// aabb_overlap_resolve
// Minimum-translation overlap resolution for one mover/obstacle box pair.
// ----------------------------------------------------------------------------
// Takes one box pair per cycle while s_tready is high and returns one
// result beat per pair, in order, through four register stages (side
// overlaps, magnitudes and hit test, side choice, push and saturation).
// Each stage stalls on its own, so a waiting result does not keep a new
// pair out while any stage has room. The user must write stair height and
// shift over APB only while no pair is in flight; the block does not enforce this.
module aabb_overlap_resolve #(
    parameter int COORD_BITS = aor_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = aor_pkg::FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [aor_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [aor_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [aor_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                              pready,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // mover_x, mover_y, mover_w, mover_h, mover_vx, mover_vy,
    // obstacle_x, obstacle_y, obstacle_w, obstacle_h, zero pad
    input  logic [((6*COORD_BITS+4*aor_pkg::SIZE_BITS+7)/8)*8-1:0] s_tdata,
    // enable
    input  logic [0:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // new_x, new_y, new_vx, new_vy, zero pad
    output logic [((4*COORD_BITS+7)/8)*8-1:0] m_tdata,
    // hit, moved, from_left, from_top, push_kind[1:0]
    output logic [5:0]                        m_tuser
);
    import aor_pkg::*;

    localparam int C         = COORD_BITS;
    localparam int MAXB      = (C > SIZE_BITS + 1) ? C : SIZE_BITS + 1;
    localparam int WIDE_BITS = MAXB + 2;
    localparam int OUT_BITS  = 4*C;
    localparam int OUT_PAD   = ((OUT_BITS + 7)/8)*8 - OUT_BITS;

    localparam int O_MY  = C;
    localparam int O_MW  = 2*C;
    localparam int O_MH  = 2*C + SIZE_BITS;
    localparam int O_VX  = 2*C + 2*SIZE_BITS;
    localparam int O_VY  = 3*C + 2*SIZE_BITS;
    localparam int O_OX  = 4*C + 2*SIZE_BITS;
    localparam int O_OY  = 5*C + 2*SIZE_BITS;
    localparam int O_OW  = 6*C + 2*SIZE_BITS;
    localparam int O_OH  = 6*C + 3*SIZE_BITS;

    cfg_t                         cfg;
    pair_flags_t                  flags;
    logic                         mid_valid, mid_ready;
    logic signed [C-1:0]          ax, ay, vx, vy;
    logic signed [WIDE_BITS-1:0]  ol, orr, ot, obt;
    logic [WIDE_BITS-1:0]         abs_ol, abs_orr, abs_ot, abs_obt;
    logic                         hit, moved, from_left, from_top;
    logic signed [C-1:0]          new_x, new_y, new_vx, new_vy;
    push_kind_t                   push_kind;

    aor_cfg #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    aor_measure #(
        .COORD_BITS (C),
        .WIDE_BITS  (WIDE_BITS)
    ) u_measure (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .mover_x    (s_tdata[0 +: C]),
        .mover_y    (s_tdata[O_MY +: C]),
        .mover_w    (s_tdata[O_MW +: SIZE_BITS]),
        .mover_h    (s_tdata[O_MH +: SIZE_BITS]),
        .mover_vx   (s_tdata[O_VX +: C]),
        .mover_vy   (s_tdata[O_VY +: C]),
        .obstacle_x (s_tdata[O_OX +: C]),
        .obstacle_y (s_tdata[O_OY +: C]),
        .obstacle_w (s_tdata[O_OW +: SIZE_BITS]),
        .obstacle_h (s_tdata[O_OH +: SIZE_BITS]),
        .enable     (s_tuser[0]),
        .out_valid  (mid_valid),
        .out_ready  (mid_ready),
        .ax         (ax),
        .ay         (ay),
        .vx         (vx),
        .vy         (vy),
        .ol         (ol),
        .orr        (orr),
        .ot         (ot),
        .obt        (obt),
        .abs_ol     (abs_ol),
        .abs_orr    (abs_orr),
        .abs_ot     (abs_ot),
        .abs_obt    (abs_obt),
        .flags      (flags)
    );

    aor_resolve #(
        .COORD_BITS (C),
        .WIDE_BITS  (WIDE_BITS)
    ) u_resolve (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .ax        (ax),
        .ay        (ay),
        .vx        (vx),
        .vy        (vy),
        .ol        (ol),
        .orr       (orr),
        .ot        (ot),
        .obt       (obt),
        .abs_ol    (abs_ol),
        .abs_orr   (abs_orr),
        .abs_ot    (abs_ot),
        .abs_obt   (abs_obt),
        .flags     (flags),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .hit       (hit),
        .moved     (moved),
        .new_x     (new_x),
        .new_y     (new_y),
        .new_vx    (new_vx),
        .new_vy    (new_vy),
        .from_left (from_left),
        .from_top  (from_top),
        .push_kind (push_kind)
    );

    generate
        if (OUT_PAD > 0) begin : g_out_pad
            assign m_tdata = {{OUT_PAD{1'b0}}, new_vy, new_vx, new_y, new_x};
        end else begin : g_out_nopad
            assign m_tdata = {new_vy, new_vx, new_y, new_x};
        end
    endgenerate

    assign m_tuser = {push_kind, from_top, from_left, moved, hit};

endmodule
